FILE: rtl/tlh_pkg.sv
// Shared types, sizes and the next-generation row rule for the toroidal Life engine.
// No dependencies; the cell, next-row unit and core import this package, the interfaces do not.
`timescale 1ns / 1ps
`default_nettype none

package tlh_pkg;

	localparam int GRID_ROWS     = 25;
	localparam int GRID_COLS     = 25;
	localparam int HISTORY_DEPTH = 8;

	localparam int FIELD_W   = 25;
	localparam int IDX_W     = 5;
	localparam int EMIT_MAX  = 25;
	localparam int EMIT_ROWS = (GRID_ROWS < EMIT_MAX) ? GRID_ROWS : EMIT_MAX;
	localparam int ROW_W     = $clog2(GRID_ROWS);

	typedef logic [GRID_COLS-1:0] row_t;
	typedef logic [ROW_W-1:0]     row_idx_t;
	typedef logic [FIELD_W-1:0]   field_t;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_STEP  = 2'd2,
		REQ_NONE  = 2'd3
	} req_code_t;

	// Per-cycle command to every history cell
	typedef struct packed {
		logic     clear;
		logic     shift;
		logic     first;
		logic     rotate;
		logic     wr_en;
		row_idx_t wr_idx;
	} cell_ctl_t;

	// B3/S23 on one row, wrapping at both column edges
	function automatic row_t life_row(input row_t up, input row_t mid, input row_t dn);
		row_t       res;
		logic [3:0] n;
		int         cl;
		int         cr;
		res = '0;
		for (int c = 0; c < GRID_COLS; c++) begin
			cl = (c + GRID_COLS - 1) % GRID_COLS;
			cr = (c + 1) % GRID_COLS;
			n  = 4'(up[cl]) + 4'(up[c]) + 4'(up[cr]) + 4'(mid[cl]) + 4'(mid[cr])
			   + 4'(dn[cl]) + 4'(dn[c]) + 4'(dn[cr]);
			res[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
		end
		return res;
	endfunction

	function automatic row_t field_to_row(input field_t f);
		row_t r;
		r = '0;
		for (int i = 0; i < GRID_COLS; i++) begin
			if (i < FIELD_W) begin
				r[i] = f[i];
			end
		end
		return r;
	endfunction

	function automatic field_t row_to_field(input row_t r);
		field_t f;
		f = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (i < GRID_COLS) begin
				f[i] = r[i];
			end
		end
		return f;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tlh_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tlh_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [4:0]  row_index;
	logic [24:0] row_cells;

	modport source (output valid, req_type, row_index, row_cells, input ready);
	modport sink   (input valid, req_type, row_index, row_cells, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlh_row_if.sv
// Result channel: valid/ready handshake carrying one emitted board row.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tlh_row_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_row_index;
	logic [24:0] out_row_cells;
	logic        last_row;
	logic        repeat_found;

	modport source (output valid, out_row_index, out_row_cells, last_row, repeat_found,
		input ready);
	modport sink   (input valid, out_row_index, out_row_cells, last_row, repeat_found,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/tlh_cell.sv
// One history slot: a board held as a circular line of rows, plus its repeat match flag.
// Depends on tlh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlh_cell import tlh_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire row_t      wr_data,
	input  wire row_t      shift_in,
	input  wire row_t      cmp_row,
	input  wire logic      cmp_en,
	input  wire logic      hit_in,
	output logic           hit_out,
	output row_t           head,
	output row_t           second,
	output row_t           tail
);

	row_t line_q [GRID_ROWS];
	logic match_q;

	assign head    = line_q[0];
	assign second  = line_q[1];
	assign tail    = line_q[GRID_ROWS-1];
	assign hit_out = hit_in | (cmp_en & match_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_ROWS; i++) begin
				line_q[i] <= '0;
			end
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			for (int i = 0; i < GRID_ROWS; i++) begin
				line_q[i] <= '0;
			end
			match_q <= 1'b0;
		end else if (ctl.shift) begin
			// hand the outgoing row on, take the shift-in row (the predecessor's head, or the new row in cell 0) at the tail
			for (int i = 0; i < GRID_ROWS - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[GRID_ROWS-1] <= shift_in;
			match_q <= (ctl.first | match_q) & (line_q[0] == cmp_row);
		end else if (ctl.rotate) begin
			for (int i = 0; i < GRID_ROWS - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[GRID_ROWS-1] <= line_q[0];
		end else if (ctl.wr_en) begin
			for (int i = 0; i < GRID_ROWS; i++) begin
				if (ctl.wr_idx == ROW_W'(i)) begin
					line_q[i] <= wr_data;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tlh_next.sv
// Next-generation row unit: picks the rows above and below and applies the Life rule.
// Depends on tlh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlh_next import tlh_pkg::*; (
	input  wire logic clk,
	input  wire logic adv,
	input  wire logic first,
	input  wire logic last,
	input  wire row_t head,
	input  wire row_t second,
	input  wire row_t tail,
	output row_t      new_row
);

	row_t prev_q;
	row_t row0_q;
	row_t up;
	row_t dn;

	// the line is being overwritten behind the head, so keep the old rows we still need
	always_ff @(posedge clk) begin
		if (adv) begin
			prev_q <= head;
			if (first) begin
				row0_q <= head;
			end
		end
	end

	assign up      = first ? tail : prev_q;
	assign dn      = last ? row0_q : second;
	assign new_row = life_row(up, head, dn);

endmodule

`default_nettype wire

FILE: rtl/toroidal_life_engine_with_history_core.sv
// Toroidal B3/S23 Life engine with a ring of stored generations. Clear and write items
// act in the cycle they are accepted. A step item sweeps the current board through the
// history cell chain, one new row per cycle, shifting every stored board one cell along
// and comparing the board in each cell but the last against the new rows; it then emits
// EMIT_ROWS result items at up to one per cycle while the output is not stalled. The sweep
// shifts the whole cell chain a row at a time; emission rotates only cell 0. Requests are
// taken only between steps; the last row may still be waiting.
`timescale 1ns / 1ps
`default_nettype none

module toroidal_life_engine_with_history_core import tlh_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlh_req_if.sink    req,
	tlh_row_if.source  rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	localparam row_idx_t LAST_ROW = ROW_W'(GRID_ROWS - 1);

	state_t    state_q;
	row_idx_t  cnt_q;
	cell_ctl_t ctl;
	logic      accept;
	logic      emit_adv;
	logic      emit_row;
	row_t      new_row;
	row_t      wr_data;
	row_t      heads [HISTORY_DEPTH];
	logic      hits  [HISTORY_DEPTH+1];
	row_t      second0;
	row_t      tail0;

	logic      oval_q;
	logic [4:0] oidx_q;
	field_t    ocells_q;
	logic      olast_q;
	logic      orep_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign wr_data   = field_to_row(req.row_cells);
	assign emit_row  = (32'(cnt_q) < EMIT_ROWS);
	assign emit_adv  = (state_q == ST_EMIT) && (!emit_row || !oval_q || rsp.ready);

	always_comb begin
		ctl        = '0;
		ctl.wr_idx = ROW_W'(req.row_index);
		ctl.shift  = (state_q == ST_STEP);
		ctl.first  = (cnt_q == '0);
		ctl.rotate = emit_adv;
		if (accept) begin
			unique case (req_code_t'(req.req_type))
				REQ_CLEAR: ctl.clear = 1'b1;
				REQ_WRITE: ctl.wr_en = (32'(req.row_index) < GRID_ROWS);
				REQ_STEP:  ctl.clear = 1'b0;
				REQ_NONE:  ctl.clear = 1'b0;
				default:   ctl.clear = 1'b0;
			endcase
		end
	end

	tlh_next u_next (
		.clk    (clk),
		.adv    (ctl.shift),
		.first  (ctl.first),
		.last   (cnt_q == LAST_ROW),
		.head   (heads[0]),
		.second (second0),
		.tail   (tail0),
		.new_row(new_row)
	);

	assign hits[0] = 1'b0;

	// cell 0 holds the current board; the last cell holds the slot about to be overwritten
	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
		cell_ctl_t cctl;
		always_comb begin
			cctl        = ctl;
			cctl.wr_en  = ctl.wr_en && (k == 0);
			cctl.rotate = ctl.rotate && (k == 0);
		end
		if (k == 0) begin : g_head
			tlh_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (cctl),
				.wr_data (wr_data),
				.shift_in(new_row),
				.cmp_row (new_row),
				.cmp_en  (1'b1),
				.hit_in  (hits[k]),
				.hit_out (hits[k+1]),
				.head    (heads[k]),
				.second  (second0),
				.tail    (tail0)
			);
		end else begin : g_body
			tlh_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (cctl),
				.wr_data (wr_data),
				.shift_in(heads[k-1]),
				.cmp_row (new_row),
				.cmp_en  (k < HISTORY_DEPTH - 1),
				.hit_in  (hits[k]),
				.hit_out (hits[k+1]),
				.head    (heads[k]),
				.second  (),
				.tail    ()
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req_code_t'(req.req_type) == REQ_STEP)) begin
						state_q <= ST_STEP;
						cnt_q   <= '0;
					end
				end
				ST_STEP: begin
					if (cnt_q == LAST_ROW) begin
						state_q <= ST_EMIT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_adv) begin
						if (cnt_q == LAST_ROW) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// output register: load a row when the slot is free, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit_adv && emit_row) begin
			oval_q <= 1'b1;
		end else if (rsp.ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_adv && emit_row) begin
			oidx_q   <= 5'(cnt_q);
			ocells_q <= row_to_field(heads[0]);
			olast_q  <= (32'(cnt_q) == EMIT_ROWS - 1);
			orep_q   <= hits[HISTORY_DEPTH];
		end
	end

	assign rsp.valid         = oval_q;
	assign rsp.out_row_index = oidx_q;
	assign rsp.out_row_cells = ocells_q;
	assign rsp.last_row      = olast_q;
	assign rsp.repeat_found  = orep_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_step_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == REQ_STEP)) |=> (state_q == ST_STEP) && (cnt_q == '0))
		else $error("step item did not start the sweep");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last_row) |-> (32'(rsp.out_row_index) == EMIT_ROWS - 1))
		else $error("last row mark on the wrong row");

	a_emit_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && ($past(state_q) == ST_STEP)) |-> (cnt_q == '0))
		else $error("emission did not start at row zero");

endmodule

`default_nettype wire
